FILE: hdl/hrhs_pkg.sv
package hrhs_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 24;
   localparam int unsigned OUT_LEN_W           = 24;
   localparam int unsigned STATUS_W            = 10;
   localparam int unsigned QUEUE_DEPTH         = 4;

   localparam int unsigned PREFIX_LEN  = 5;
   localparam int unsigned NAME_LEN    = 18;
   localparam int unsigned CHUNK_LEN   = 7;
   localparam int unsigned MIN_MSG_LEN = 12;
   localparam int unsigned STATUS_MIN  = 100;
   localparam int unsigned STATUS_MAX  = 999;
   localparam int unsigned STATUS_SAT  = 1000;

   // One classified input byte, front to back.
   typedef struct packed {
      logic [7:0] raw;
      logic [7:0] lower;
      logic       is_digit;
      logic [3:0] digit;
      logic       is_space;
      logic       is_cr;
      logic       is_lf;
      logic       last;
   } byte_item_type;

   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = "H";
         3'd1:    ch = "T";
         3'd2:    ch = "T";
         3'd3:    ch = "P";
         3'd4:    ch = "/";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] name_char(input logic [4:0] idx);
      logic [7:0] ch;
      unique case (idx)
         5'd0:    ch = "t";
         5'd1:    ch = "r";
         5'd2:    ch = "a";
         5'd3:    ch = "n";
         5'd4:    ch = "s";
         5'd5:    ch = "f";
         5'd6:    ch = "e";
         5'd7:    ch = "r";
         5'd8:    ch = "-";
         5'd9:    ch = "e";
         5'd10:   ch = "n";
         5'd11:   ch = "c";
         5'd12:   ch = "o";
         5'd13:   ch = "d";
         5'd14:   ch = "i";
         5'd15:   ch = "n";
         5'd16:   ch = "g";
         5'd17:   ch = ":";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] chunk_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = "c";
         3'd1:    ch = "h";
         3'd2:    ch = "u";
         3'd3:    ch = "n";
         3'd4:    ch = "k";
         3'd5:    ch = "e";
         3'd6:    ch = "d";
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

FILE: hdl/hrhs_front.sv
module hrhs_front
   import hrhs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic [7:0]    req_data_byte,
   input  logic          req_last_byte,
   output logic          item_valid,
   output byte_item_type item,
   input  logic          item_ready
);

   logic          valid_ff, valid_in;
   byte_item_type item_ff, item_in;
   logic          accept;

   assign req_full = valid_ff && !item_ready;
   assign accept   = req_push && !req_full;

   always_comb begin
      item_in.raw      = req_data_byte;
      item_in.lower    = (req_data_byte >= "A" && req_data_byte <= "Z") ?
                         (req_data_byte | 8'h20) : req_data_byte;
      item_in.is_digit = (req_data_byte >= "0" && req_data_byte <= "9");
      item_in.digit    = req_data_byte[3:0];
      item_in.is_space = (req_data_byte == " ");
      item_in.is_cr    = (req_data_byte == 8'h0D);
      item_in.is_lf    = (req_data_byte == 8'h0A);
      item_in.last     = req_last_byte;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hdl/hrhs_queue.sv
module hrhs_queue
   import hrhs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  byte_item_type push_item,
   output logic          full,
   input  logic          pop,
   output byte_item_type pop_item,
   output logic          empty
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   byte_item_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: hdl/hrhs_back.sv
module hrhs_back
   import hrhs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   input  byte_item_type         q_item,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_parse_ok,
   output logic [STATUS_W-1:0]   rsp_status_code,
   output logic                  rsp_is_chunked,
   output logic [OUT_LEN_W-1:0]  rsp_header_length,
   output logic [OUT_LEN_W-1:0]  rsp_body_length
);

   localparam int unsigned EXT_W = (LENGTH_BITS > OUT_LEN_W) ? LENGTH_BITS : OUT_LEN_W;

   // status scan phases
   localparam logic [1:0] PH_SKIP_TOKEN = 2'd0;
   localparam logic [1:0] PH_SKIP_SPACE = 2'd1;
   localparam logic [1:0] PH_DIGITS     = 2'd2;
   localparam logic [1:0] PH_DONE       = 2'd3;

   // CR LF CR LF progress
   localparam logic [1:0] TM_NONE    = 2'd0;
   localparam logic [1:0] TM_CR      = 2'd1;
   localparam logic [1:0] TM_CRLF    = 2'd2;
   localparam logic [1:0] TM_CRLFCR  = 2'd3;

   // header line name match
   localparam logic [1:0] NM_MATCHING = 2'd0;
   localparam logic [1:0] NM_MATCHED  = 2'd1;
   localparam logic [1:0] NM_FAILED   = 2'd2;

   logic [LENGTH_BITS-1:0] count_ff, count_in;
   logic                   ovf_ff, ovf_in;
   logic                   prefix_ff, prefix_in;
   logic [1:0]             phase_ff, phase_in;
   logic [STATUS_W-1:0]    accum_ff, accum_in;
   logic [1:0]             term_ff, term_in;
   logic                   found_ff, found_in;
   logic [LENGTH_BITS-1:0] hdr_end_ff, hdr_end_in;
   logic [4:0]             name_pos_ff, name_pos_in;
   logic [1:0]             name_st_ff, name_st_in;
   logic [2:0]             chunk_pos_ff, chunk_pos_in;
   logic                   chunked_ff, chunked_in;

   logic                   out_valid_ff, out_valid_in;
   logic                   ok_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic                   is_chunked_ff;
   logic [OUT_LEN_W-1:0]   hdr_len_ff, body_len_ff;

   logic                   take, done, ok, prev_cr;
   logic [13:0]            scaled;
   logic [LENGTH_BITS-1:0] body_raw;
   logic [EXT_W-1:0]       hdr_ext, body_ext;

   assign q_pop = !q_empty && !(q_item.last && out_valid_ff && !rsp_pop);
   assign take  = q_pop;
   assign done  = take && q_item.last;

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      prefix_in    = prefix_ff;
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      term_in      = term_ff;
      found_in     = found_ff;
      hdr_end_in   = hdr_end_ff;
      name_pos_in  = name_pos_ff;
      name_st_in   = name_st_ff;
      chunk_pos_in = chunk_pos_ff;
      chunked_in   = chunked_ff;
      prev_cr      = (term_ff == TM_CR) || (term_ff == TM_CRLFCR);
      scaled       = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                     + {10'd0, q_item.digit};

      // byte counter, sticks at all ones
      if (count_ff == '1) begin
         ovf_in = 1'b1;
      end else begin
         count_in = count_ff + 1'b1;
      end

      if (!ovf_in && count_ff < LENGTH_BITS'(PREFIX_LEN) &&
          q_item.raw != prefix_char(count_ff[2:0])) begin
         prefix_in = 1'b0;
      end

      unique case (phase_ff)
         PH_SKIP_TOKEN: begin
            if (q_item.is_space) begin
               phase_in = PH_SKIP_SPACE;
            end
         end
         PH_SKIP_SPACE, PH_DIGITS: begin
            if (q_item.is_digit) begin
               accum_in = (scaled > 14'(STATUS_MAX)) ? STATUS_W'(STATUS_SAT)
                                                     : scaled[STATUS_W-1:0];
               phase_in = PH_DIGITS;
            end else if (!(phase_ff == PH_SKIP_SPACE && q_item.is_space)) begin
               phase_in = PH_DONE;
            end
         end
         PH_DONE: begin
         end
      endcase

      if (!found_ff) begin
         if (q_item.is_lf && prev_cr) begin
            name_pos_in  = '0;
            name_st_in   = NM_MATCHING;
            chunk_pos_in = '0;
         end else begin
            if (name_st_ff == NM_MATCHING) begin
               if (name_pos_ff < 5'(NAME_LEN) && q_item.lower == name_char(name_pos_ff)) begin
                  name_pos_in = name_pos_ff + 1'b1;
                  if (name_pos_in == 5'(NAME_LEN)) begin
                     name_st_in = NM_MATCHED;
                  end
               end else begin
                  name_st_in = NM_FAILED;
               end
            end
            if (chunk_pos_ff < 3'(CHUNK_LEN) &&
                q_item.lower == chunk_char(chunk_pos_ff)) begin
               if (chunk_pos_ff == 3'(CHUNK_LEN - 1)) begin
                  if (name_st_in == NM_MATCHED) begin
                     chunked_in = 1'b1;
                  end
                  chunk_pos_in = '0;
               end else begin
                  chunk_pos_in = chunk_pos_ff + 1'b1;
               end
            end else begin
               chunk_pos_in = (q_item.lower == chunk_char(3'd0)) ? 3'd1 : 3'd0;
            end
         end

         unique case (term_ff)
            TM_NONE: begin
               term_in = q_item.is_cr ? TM_CR : TM_NONE;
            end
            TM_CR: begin
               term_in = q_item.is_lf ? TM_CRLF : (q_item.is_cr ? TM_CR : TM_NONE);
            end
            TM_CRLF: begin
               term_in = q_item.is_cr ? TM_CRLFCR : TM_NONE;
            end
            TM_CRLFCR: begin
               if (q_item.is_lf) begin
                  found_in   = 1'b1;
                  hdr_end_in = count_in;
                  term_in    = TM_NONE;
               end else begin
                  term_in = q_item.is_cr ? TM_CR : TM_NONE;
               end
            end
         endcase
      end
   end

   // result of the final byte
   assign ok = !ovf_in && count_in >= LENGTH_BITS'(MIN_MSG_LEN) && prefix_in &&
               accum_in >= STATUS_W'(STATUS_MIN) && accum_in <= STATUS_W'(STATUS_MAX) &&
               found_in;
   assign body_raw = count_in - hdr_end_in;
   assign hdr_ext  = EXT_W'(hdr_end_in);
   assign body_ext = EXT_W'(body_raw);

   always_ff @(posedge clock) begin
      if (reset || done) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         prefix_ff    <= 1'b1;
         phase_ff     <= PH_SKIP_TOKEN;
         accum_ff     <= '0;
         term_ff      <= TM_NONE;
         found_ff     <= 1'b0;
         hdr_end_ff   <= '0;
         name_pos_ff  <= '0;
         name_st_ff   <= NM_MATCHING;
         chunk_pos_ff <= '0;
         chunked_ff   <= 1'b0;
      end else if (take) begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         prefix_ff    <= prefix_in;
         phase_ff     <= phase_in;
         accum_ff     <= accum_in;
         term_ff      <= term_in;
         found_ff     <= found_in;
         hdr_end_ff   <= hdr_end_in;
         name_pos_ff  <= name_pos_in;
         name_st_ff   <= name_st_in;
         chunk_pos_ff <= chunk_pos_in;
         chunked_ff   <= chunked_in;
      end
   end

   always_comb begin
      if (done) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         ok_ff         <= ok;
         status_ff     <= ok ? accum_in : '0;
         is_chunked_ff <= ok && chunked_in;
         hdr_len_ff    <= ok ? hdr_ext[OUT_LEN_W-1:0] : '0;
         body_len_ff   <= ok ? body_ext[OUT_LEN_W-1:0] : '0;
      end
   end

   assign rsp_empty         = !out_valid_ff;
   assign rsp_parse_ok      = ok_ff;
   assign rsp_status_code   = status_ff;
   assign rsp_is_chunked    = is_chunked_ff;
   assign rsp_header_length = hdr_len_ff;
   assign rsp_body_length   = body_len_ff;

endmodule

FILE: hdl/http_response_header_scan.sv
// The final byte reaches the rsp_ ports through the front register, a queue write,
//   and then the scan stage loading the result register.
// Throughput: one byte per cycle when neither a full queue nor an untaken result stalls.
// A 4-entry queue between front and scan stage absorbs rsp_ back-pressure.
// Reset: synchronous, active high; empties all stages and returns the scan state
//   to its start-of-message values. The same clear happens after every final byte.
module http_response_header_scan
   import hrhs_pkg::*;
#(
   parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  logic                  reset,
   // input channel: one message byte per item
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_last_byte,
   // result channel: one item per message
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic                  rsp_parse_ok,
   output logic [STATUS_W-1:0]   rsp_status_code,
   output logic                  rsp_is_chunked,
   output logic [OUT_LEN_W-1:0]  rsp_header_length,
   output logic [OUT_LEN_W-1:0]  rsp_body_length
);

   // front stage -> queue
   byte_item_type front_item;
   logic          front_valid;
   logic          q_full;

   // queue -> scan stage
   byte_item_type q_item;
   logic          q_empty;
   logic          q_pop;

   // Front: registers the byte and precomputes case folding and character classes
   // (digit, space, CR, LF) so the scan stage only does state updates.
   hrhs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .item_valid    (front_valid),
      .item          (front_item),
      .item_ready    (!q_full)
   );

   // Decoupling queue; the front stalls only when it fills.
   hrhs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .pop_item  (q_item),
      .empty     (q_empty)
   );

   // Scan stage: byte count, HTTP/ prefix check, status digits, CR LF CR LF
   // search, transfer-encoding / chunked match, and the result register.
   // It holds a final byte only while an untaken result still sits in the register.
   hrhs_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_item            (q_item),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_parse_ok      (rsp_parse_ok),
      .rsp_status_code   (rsp_status_code),
      .rsp_is_chunked    (rsp_is_chunked),
      .rsp_header_length (rsp_header_length),
      .rsp_body_length   (rsp_body_length)
   );

endmodule

FILE: hdl/hrhs_checker.sv
module hrhs_checker
   import hrhs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_full,
   input logic                  rsp_empty,
   input logic                  rsp_pop,
   input logic                  rsp_parse_ok,
   input logic [STATUS_W-1:0]   rsp_status_code,
   input logic                  rsp_is_chunked,
   input logic [OUT_LEN_W-1:0]  rsp_header_length,
   input logic [OUT_LEN_W-1:0]  rsp_body_length
);

   // reset leaves no result pending and the input open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("state after reset not clear");

   // a failed parse reports all fields as zero
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_parse_ok) |->
         (rsp_status_code == '0) && !rsp_is_chunked &&
         (rsp_header_length == '0) && (rsp_body_length == '0))
      else $error("failed parse with nonzero fields");

   // a good parse carries a status inside the accepted range
   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_parse_ok) |->
         (rsp_status_code >= STATUS_W'(STATUS_MIN)) &&
         (rsp_status_code <= STATUS_W'(STATUS_MAX)))
      else $error("good parse with status out of range");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         !rsp_empty && $stable(rsp_parse_ok) && $stable(rsp_status_code) &&
         $stable(rsp_header_length) && $stable(rsp_body_length))
      else $error("waiting result changed");

endmodule

bind http_response_header_scan hrhs_checker u_checker (.*);
